// ----- src/cell_downsample_shade_stats_unit_assert.svh -----
// Assertion macros shared by the cell shade statistics RTL.
`ifndef CELL_DOWNSAMPLE_SHADE_STATS_UNIT_ASSERT_SVH
`define CELL_DOWNSAMPLE_SHADE_STATS_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CSSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CSSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/csss_pkg.sv -----
// Types and constants of the cell shade statistics unit.
`timescale 1ns / 1ps
`default_nettype none

package csss_pkg;

  localparam int COMP_W     = 6;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = 12;
  localparam int CELL_EXT_W = 17;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 8;
  localparam int FILL_W     = 3;
  localparam int LUMA_W     = 16;
  localparam int STORE_W    = 28;
  localparam int DIVD_W     = 16;
  localparam int DIVS_W     = 8;
  localparam int DIV_STEPS  = 16;
  localparam int STEP_W     = 4;

  localparam logic [LUMA_W-1:0]  LUMA_KR       = 16'd77;
  localparam logic [LUMA_W-1:0]  LUMA_KG       = 16'd150;
  localparam logic [LUMA_W-1:0]  LUMA_KB       = 16'd29;
  localparam logic [COLOR_W-1:0] THRESH_RESET  = 8'd16;
  localparam logic [FILL_W-1:0]  FILL_MAX      = 3'd4;
  localparam logic [STORE_W-1:0] STORE_RESET   = 28'h0FF_FFFF | 28'hF00_0000;

  typedef struct packed {
    logic [COMP_W-1:0] pixel_red;
    logic [COMP_W-1:0] pixel_green;
    logic [COMP_W-1:0] pixel_blue;
    logic [CELL_W-1:0] cell_number;
    logic              cell_end;
  } pixel_t;

  typedef struct packed {
    logic [CELL_W-1:0]  out_cell;
    logic [COLOR_W-1:0] avg_red;
    logic [COLOR_W-1:0] avg_green;
    logic [COLOR_W-1:0] avg_blue;
    logic [FILL_W-1:0]  fill_level;
    logic               cell_changed;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_ACC   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- src/csss_div.sv -----
// Restoring divider lane, one quotient bit per step.
`timescale 1ns / 1ps
`default_nettype none

module csss_div (
  input  wire logic                          clk,
  input  wire csss_pkg::div_ctrl_t           ctrl,
  input  wire logic [csss_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [csss_pkg::DIVS_W-1:0]   divisor,
  output logic      [csss_pkg::DIVD_W-1:0]   quotient
);

  logic [csss_pkg::DIVS_W-1:0] rem_r, rem_nxt;
  logic [csss_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [csss_pkg::DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [csss_pkg::DIVS_W:0]   shifted;
  logic [csss_pkg::DIVS_W+1:0] trial;

  // Shift in the next dividend bit and try to subtract the held divisor.
  always_comb begin
    shifted = {rem_r, quo_r[csss_pkg::DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    if (ctrl.load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (ctrl.step) begin
      if (!trial[csss_pkg::DIVS_W+1]) begin
        rem_nxt = trial[csss_pkg::DIVS_W-1:0];
        quo_nxt = {quo_r[csss_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[csss_pkg::DIVS_W-1:0];
        quo_nxt = {quo_r[csss_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- src/csss_store.sv -----
// Per-cell word store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module csss_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [csss_pkg::STORE_W-1:0]  wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [csss_pkg::STORE_W-1:0]  rd_data
);

  logic [csss_pkg::STORE_W-1:0] mem [DEPTH];
  logic [csss_pkg::STORE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/cell_downsample_shade_stats_unit.sv -----
// Top level of the cell shade statistics unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | csss_pkg::pixel_t, one pixel
//  out_    | output    | out_valid/out_stall| csss_pkg::result_t, one cell
//  cfg_    | input     | cfg_valid/cfg_ready| dark_threshold, 8 bits
//
// A pixel without cell_end is accepted and the next one can follow at once.
// On a pixel with cell_end the unit accumulates and reads the cell store, then
// runs the shared-step restoring dividers (one quotient bit per cycle), then
// compares and writes back before the next transfer. ST_FIN waits while the
// output register holds a result that is stalled. After reset the cell store
// is swept to all ones, one entry per cycle, while in_stall stays high.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module cell_downsample_shade_stats_unit #(
  parameter int MAX_CELLS       = 4096,
  parameter int MAX_CELL_PIXELS = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire csss_pkg::pixel_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output csss_pkg::result_t                      out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [csss_pkg::COLOR_W-1:0]      cfg_data
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  localparam logic [csss_pkg::CNT_W-1:0]      PIX_BOUND = csss_pkg::CNT_W'(MAX_CELL_PIXELS);
  localparam logic [csss_pkg::CELL_EXT_W-1:0] CELL_LIM  = csss_pkg::CELL_EXT_W'(MAX_CELLS);
  localparam logic [AW-1:0]                   CLR_LAST  = AW'(MAX_CELLS - 1);
  localparam logic [csss_pkg::STEP_W-1:0]     STEP_LAST = csss_pkg::STEP_W'(csss_pkg::DIV_STEPS - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  csss_pkg::state_t                  state_r, state_nxt;
  logic [AW-1:0]                     clr_addr_r, clr_addr_nxt;
  logic [csss_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [csss_pkg::COLOR_W-1:0]      thresh_r, thresh_nxt;

  logic [csss_pkg::SUM_W-1:0]        red_sum_r, red_sum_nxt;
  logic [csss_pkg::SUM_W-1:0]        green_sum_r, green_sum_nxt;
  logic [csss_pkg::SUM_W-1:0]        blue_sum_r, blue_sum_nxt;
  logic [csss_pkg::CNT_W-1:0]        lit_r, lit_nxt;
  logic [csss_pkg::CNT_W-1:0]        pcount_r, pcount_nxt;

  // Snapshot of the finishing cell, held through division and write-back.
  logic [csss_pkg::CELL_W-1:0]       cell_r, cell_nxt;
  logic                              in_range_r, in_range_nxt;
  logic                              any_lit_r, any_lit_nxt;

  logic                              out_valid_r, out_valid_nxt;
  csss_pkg::result_t                 out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Pixel datapath: widen, luma, accumulate
  // ---------------------------------------------------------------------------
  logic                              in_xfer;
  logic [csss_pkg::COLOR_W-1:0]      r8, g8, b8;
  logic [csss_pkg::LUMA_W-1:0]       luma_full;
  logic                              pix_lit;
  logic                              pix_counted;
  logic [csss_pkg::SUM_W-1:0]        red_acc, green_acc, blue_acc;
  logic [csss_pkg::CNT_W-1:0]        lit_acc, pcount_acc;
  logic [csss_pkg::CELL_EXT_W-1:0]   cell_ext;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != csss_pkg::ST_ACC);

  // Widen 6-bit DAC values by bit replication.
  assign r8 = {in_data.pixel_red,   in_data.pixel_red[5:4]};
  assign g8 = {in_data.pixel_green, in_data.pixel_green[5:4]};
  assign b8 = {in_data.pixel_blue,  in_data.pixel_blue[5:4]};

  // Constant weights sum to 256, so the weighted sum fits 16 bits.
  assign luma_full = csss_pkg::LUMA_KR * {8'd0, r8}
                   + csss_pkg::LUMA_KG * {8'd0, g8}
                   + csss_pkg::LUMA_KB * {8'd0, b8};
  assign pix_lit     = (luma_full[csss_pkg::LUMA_W-1:8] >= thresh_r);
  // Drop the pixel once the count sits at its bound.
  assign pix_counted = (pcount_r < PIX_BOUND);

  always_comb begin
    red_acc    = red_sum_r;
    green_acc  = green_sum_r;
    blue_acc   = blue_sum_r;
    lit_acc    = lit_r;
    pcount_acc = pcount_r;
    if (pix_counted) begin
      pcount_acc = pcount_r + 1'b1;
      if (pix_lit) begin
        red_acc   = red_sum_r   + {8'd0, r8};
        green_acc = green_sum_r + {8'd0, g8};
        blue_acc  = blue_sum_r  + {8'd0, b8};
        lit_acc   = lit_r + 1'b1;
      end
    end
  end

  assign cell_ext = {{(csss_pkg::CELL_EXT_W - csss_pkg::CELL_W){1'b0}}, in_data.cell_number};

  // ---------------------------------------------------------------------------
  // Dividers: three channel averages and the fill ratio
  // ---------------------------------------------------------------------------
  csss_pkg::div_ctrl_t               div_ctrl;
  logic [csss_pkg::DIVD_W-1:0]       fill_dividend;
  logic [csss_pkg::DIVD_W-1:0]       q_red, q_green, q_blue, q_fill;

  assign div_ctrl.load = in_xfer && in_data.cell_end;
  assign div_ctrl.step = (state_r == csss_pkg::ST_DIV);

  // lit * 3, at most 765.
  assign fill_dividend = {7'd0, lit_acc, 1'b0} + {8'd0, lit_acc};

  csss_div u_div_red (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (red_acc),
    .divisor  (lit_acc),
    .quotient (q_red)
  );

  csss_div u_div_green (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (green_acc),
    .divisor  (lit_acc),
    .quotient (q_green)
  );

  csss_div u_div_blue (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (blue_acc),
    .divisor  (lit_acc),
    .quotient (q_blue)
  );

  csss_div u_div_fill (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (fill_dividend),
    .divisor  (pcount_acc),
    .quotient (q_fill)
  );

  // ---------------------------------------------------------------------------
  // Cell store. The read is issued on the finishing pixel; the write lands in
  // ST_FIN before the next pixel can be taken, so the FSM itself is the
  // interlock between a write-back and a later read of the same cell.
  // ---------------------------------------------------------------------------
  logic                              st_wr_en;
  logic [AW-1:0]                     st_wr_addr;
  logic [csss_pkg::STORE_W-1:0]      st_wr_data;
  logic [csss_pkg::STORE_W-1:0]      st_rd_data;
  logic                              out_free;
  logic                              fin_go;
  logic [csss_pkg::COLOR_W-1:0]      avg_r, avg_g, avg_b;
  logic [csss_pkg::FILL_W-1:0]       fill;
  logic [csss_pkg::STORE_W-1:0]      word;
  logic [csss_pkg::STORE_W-1:0]      prev_word;
  logic [csss_pkg::CELL_EXT_W-1:0]   cell_r_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_go   = (state_r == csss_pkg::ST_FIN) && out_free;

  assign cell_r_ext = {{(csss_pkg::CELL_EXT_W - csss_pkg::CELL_W){1'b0}}, cell_r};

  always_comb begin
    avg_r = '0;
    avg_g = '0;
    avg_b = '0;
    fill  = '0;
    if (any_lit_r) begin
      avg_r = q_red[csss_pkg::COLOR_W-1:0];
      avg_g = q_green[csss_pkg::COLOR_W-1:0];
      avg_b = q_blue[csss_pkg::COLOR_W-1:0];
      // Quotient of 3*lit/count is at most 3; cap anyway.
      if (q_fill > csss_pkg::DIVD_W'(3)) begin
        fill = csss_pkg::FILL_MAX;
      end else begin
        fill = q_fill[csss_pkg::FILL_W-1:0] + 1'b1;
      end
    end
  end

  assign word      = {1'b0, fill, avg_r, avg_g, avg_b};
  // An out-of-range cell has no entry and compares as against all ones.
  assign prev_word = in_range_r ? st_rd_data : csss_pkg::STORE_RESET;

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = cell_r_ext[AW-1:0];
    st_wr_data = word;
    if (state_r == csss_pkg::ST_CLEAR) begin
      st_wr_en   = 1'b1;
      st_wr_addr = clr_addr_r;
      st_wr_data = csss_pkg::STORE_RESET;
    end else if (fin_go && in_range_r) begin
      st_wr_en = 1'b1;
    end
  end

  csss_store #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (div_ctrl.load),
    .rd_addr (cell_ext[AW-1:0]),
    .rd_data (st_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    thresh_nxt    = thresh_r;
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    lit_nxt       = lit_r;
    pcount_nxt    = pcount_r;
    cell_nxt      = cell_r;
    in_range_nxt  = in_range_r;
    any_lit_nxt   = any_lit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      thresh_nxt = cfg_data;
    end

    // Retire the held result once it transfers.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      csss_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = csss_pkg::ST_ACC;
        end
      end
      csss_pkg::ST_ACC: begin
        if (in_xfer) begin
          if (in_data.cell_end) begin
            // Hand the totals to the dividers and restart the accumulators.
            red_sum_nxt   = '0;
            green_sum_nxt = '0;
            blue_sum_nxt  = '0;
            lit_nxt       = '0;
            pcount_nxt    = '0;
            cell_nxt      = in_data.cell_number;
            in_range_nxt  = (cell_ext < CELL_LIM);
            any_lit_nxt   = (lit_acc != '0);
            step_nxt      = '0;
            state_nxt     = csss_pkg::ST_DIV;
          end else begin
            red_sum_nxt   = red_acc;
            green_sum_nxt = green_acc;
            blue_sum_nxt  = blue_acc;
            lit_nxt       = lit_acc;
            pcount_nxt    = pcount_acc;
          end
        end
      end
      csss_pkg::ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = csss_pkg::ST_FIN;
        end
      end
      csss_pkg::ST_FIN: begin
        // Hold until the output register is free, then load it and write back.
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_cell     = cell_r;
          out_data_nxt.avg_red      = avg_r;
          out_data_nxt.avg_green    = avg_g;
          out_data_nxt.avg_blue     = avg_b;
          out_data_nxt.fill_level   = fill;
          out_data_nxt.cell_changed = (word != prev_word);
          state_nxt                 = csss_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = csss_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csss_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= '0;
      thresh_r    <= csss_pkg::THRESH_RESET;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      lit_r       <= '0;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      thresh_r    <= thresh_nxt;
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      lit_r       <= lit_nxt;
      pcount_r    <= pcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    in_range_r <= in_range_nxt;
    any_lit_r  <= any_lit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "cell_downsample_shade_stats_unit_assert.svh"

  `CSSS_ASSERT_NEXT(a_last_starts_div, in_xfer && in_data.cell_end, state_r == csss_pkg::ST_DIV, "finishing pixel did not start division")
  `CSSS_ASSERT_SAME(a_lit_le_count, 1'b1, lit_r <= pcount_r, "lit count exceeds pixel count")
  `CSSS_ASSERT_SAME(a_count_bound, 1'b1, pcount_r <= PIX_BOUND, "pixel count passed its bound")
  `CSSS_ASSERT_SAME(a_result_from_fin, $rose(out_valid_r), $past(state_r) == csss_pkg::ST_FIN, "result appeared outside write-back")

endmodule

`default_nettype wire
